// File: hw/rtl/ctd_pkg.sv
package ctd_pkg;

    // Default width of the chunk size counter.
    localparam int SIZE_BITS_DEF = 32;

    // Width of the minimum-remaining estimate.
    localparam int MINREM_W = 33;

    // Framing characters.
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_SEMI = 8'h3B;
    localparam logic [7:0] BYTE_SP   = 8'h20;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Parse states.
    typedef enum logic [3:0] {
        ST_START       = 4'd0,
        ST_SIZE        = 4'd1,
        ST_EXT         = 4'd2,
        ST_EXT_CR      = 4'd3,
        ST_DATA        = 4'd4,
        ST_AFTER       = 4'd5,
        ST_AFTER_CR    = 4'd6,
        ST_LAST_EXT    = 4'd7,
        ST_LAST_EXT_CR = 4'd8,
        ST_TRAILER     = 4'd9,
        ST_TRAILER_CR  = 4'd10,
        ST_THDR        = 4'd11,
        ST_THDR_CR     = 4'd12
    } t_parse_state;

    // Byte classification.
    typedef enum logic [1:0] {
        K_FRAME   = 2'd0,
        K_PAYLOAD = 2'd1,
        K_DONE    = 2'd2,
        K_ERROR   = 2'd3
    } t_kind;

    // Outcome of one byte that does not depend on the size width.
    typedef struct packed {
        t_kind                kind;
        t_parse_state         state;
        logic [7:0]           payload_byte;
        logic [MINREM_W-1:0]  min_remaining;
    } t_step_res;

endpackage

// File: hw/rtl/ctd_if.sv
// Input channel: one raw byte per beat.
interface ctd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// Output channel: one classified byte per beat.
interface ctd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [32:0] min_remaining;
    logic        end_of_buffer;

    modport source (output valid, output kind, output payload_byte,
                    output min_remaining, output end_of_buffer, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input min_remaining, input end_of_buffer, output ready);
endinterface

// File: hw/rtl/chunked_transfer_decoder_unit.sv
// An accepted input beat reaches its result beat through the input register, then the
// result register; throughput: one byte per cycle while o_out.ready does not stall
// the result register.
// Reset (i_rst_n low at a clock edge) returns the parser to chunk start with a zero
// size, clears a latched error and empties both registers.
module chunked_transfer_decoder_unit
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctd_in_if.sink        i_in,
    ctd_out_if.source     o_out
);

    // Input register.
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_end;

    // Parser state.
    t_parse_state         r_state;
    logic [SIZE_BITS-1:0] r_chunk;
    logic                 r_err;

    // Result register.
    logic                 r_out_valid;
    logic [1:0]           r_out_kind;
    logic [7:0]           r_out_payload;
    logic [MINREM_W-1:0]  r_out_minrem;
    logic                 r_out_end;

    t_step_res            step_res;
    logic [SIZE_BITS-1:0] step_chunk;
    logic                 advance;

    ctd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_state (r_state),
        .i_chunk (r_chunk),
        .i_byte  (r_in_byte),
        .o_res   (step_res),
        .o_chunk (step_chunk)
    );

    // Pipeline flow control.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register loads on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.buffer_end;
        end
    end

    // Parser state update; an error freezes the parser until reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_chunk <= '0;
            r_err   <= 1'b0;
        end else if (advance && !r_err) begin
            if (step_res.kind == K_ERROR) begin
                r_err <= 1'b1;
            end else begin
                r_state <= step_res.state;
                r_chunk <= step_chunk;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_end <= r_in_end;
            if (r_err) begin
                r_out_kind    <= K_ERROR;
                r_out_payload <= 8'd0;
                r_out_minrem  <= '0;
            end else begin
                r_out_kind    <= step_res.kind;
                r_out_payload <= step_res.payload_byte;
                r_out_minrem  <= step_res.min_remaining;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.payload_byte  = r_out_payload;
    assign o_out.min_remaining = r_out_minrem;
    assign o_out.end_of_buffer = r_out_end;

endmodule

// File: hw/rtl/ctd_step.sv
module ctd_step
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  t_parse_state         i_state,
    input  logic [SIZE_BITS-1:0] i_chunk,
    input  logic [7:0]           i_byte,
    output t_step_res            o_res,
    output logic [SIZE_BITS-1:0] o_chunk
);

    localparam int SUM_W = (SIZE_BITS + 1 > MINREM_W + 1) ? SIZE_BITS + 1 : MINREM_W + 1;

    t_parse_state         eff_state;
    t_parse_state         n_state;
    logic [SIZE_BITS-1:0] n_chunk;
    t_kind                kind;
    logic                 is_hex;
    logic [3:0]           hex_val;
    logic [7:0]           lower;
    logic                 is_ext;
    logic                 chunk_nz;
    logic [SUM_W-1:0]     addend;
    logic                 use_const;
    logic [SUM_W-1:0]     sum;
    logic [MINREM_W-1:0]  min_rem;

    // Hex digit decode.
    always_comb begin
        lower   = i_byte | CASE_BIT;
        is_hex  = 1'b0;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            is_hex  = 1'b1;
            hex_val = 4'(i_byte - 8'h30);
        end else if (lower >= 8'h61 && lower <= 8'h66) begin
            is_hex  = 1'b1;
            hex_val = 4'(lower - 8'h57);
        end
    end

    assign is_ext   = (i_byte == BYTE_SEMI) || (i_byte == BYTE_SP) || (i_byte == BYTE_TAB);
    assign chunk_nz = (i_chunk != '0);

    // Next parse state and chunk size for this byte.
    always_comb begin
        eff_state = (i_state == ST_DATA && !chunk_nz) ? ST_AFTER : i_state;
        n_state   = eff_state;
        n_chunk   = i_chunk;
        kind      = K_FRAME;
        unique case (eff_state)
            ST_START: begin
                if (!is_hex) begin
                    kind = K_ERROR;
                end else begin
                    n_chunk = SIZE_BITS'(hex_val);
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                if (is_hex) begin
                    if (i_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                        kind = K_ERROR;
                    end else begin
                        n_chunk = {i_chunk[SIZE_BITS-5:0], hex_val};
                    end
                end else if (i_byte == BYTE_CR) begin
                    n_state = chunk_nz ? ST_EXT_CR : ST_LAST_EXT_CR;
                end else if (i_byte == BYTE_LF) begin
                    n_state = chunk_nz ? ST_DATA : ST_TRAILER;
                end else if (is_ext) begin
                    n_state = chunk_nz ? ST_EXT : ST_LAST_EXT;
                end else begin
                    kind = K_ERROR;
                end
            end
            ST_EXT: begin
                if (i_byte == BYTE_CR) begin
                    n_state = ST_EXT_CR;
                end else if (i_byte == BYTE_LF) begin
                    n_state = ST_DATA;
                end
            end
            ST_EXT_CR: begin
                if (i_byte == BYTE_LF) n_state = ST_DATA;
                else kind = K_ERROR;
            end
            ST_DATA: begin
                kind    = K_PAYLOAD;
                n_chunk = i_chunk - SIZE_BITS'(1);
                if (n_chunk == '0) n_state = ST_AFTER;
            end
            ST_AFTER: begin
                if (i_byte == BYTE_CR) begin
                    n_state = ST_AFTER_CR;
                end else if (i_byte == BYTE_LF) begin
                    n_state = ST_START;
                end
            end
            ST_AFTER_CR: begin
                if (i_byte == BYTE_LF) n_state = ST_START;
                else kind = K_ERROR;
            end
            ST_LAST_EXT: begin
                if (i_byte == BYTE_CR) begin
                    n_state = ST_LAST_EXT_CR;
                end else if (i_byte == BYTE_LF) begin
                    n_state = ST_TRAILER;
                end
            end
            ST_LAST_EXT_CR: begin
                if (i_byte == BYTE_LF) n_state = ST_TRAILER;
                else kind = K_ERROR;
            end
            ST_TRAILER: begin
                if (i_byte == BYTE_CR) begin
                    n_state = ST_TRAILER_CR;
                end else if (i_byte == BYTE_LF) begin
                    kind = K_DONE;
                end else begin
                    n_state = ST_THDR;
                end
            end
            ST_TRAILER_CR: begin
                if (i_byte == BYTE_LF) kind = K_DONE;
                else kind = K_ERROR;
            end
            ST_THDR: begin
                if (i_byte == BYTE_CR) begin
                    n_state = ST_THDR_CR;
                end else if (i_byte == BYTE_LF) begin
                    n_state = ST_TRAILER;
                end
            end
            ST_THDR_CR: begin
                if (i_byte == BYTE_LF) n_state = ST_TRAILER;
                else kind = K_ERROR;
            end
            default: begin
                kind = K_ERROR;
            end
        endcase

        // End of message returns to the start of the next chunk.
        if (kind == K_DONE) begin
            n_state = ST_START;
            n_chunk = '0;
        end
    end

    // Lower bound on bytes still to come, from the state after this byte.
    always_comb begin
        use_const = 1'b1;
        addend    = SUM_W'(2);
        unique case (n_state)
            ST_START:                        addend = SUM_W'(3);
            ST_SIZE: begin
                use_const = (n_chunk == '0);
                addend    = use_const ? SUM_W'(2) : SUM_W'(5);
            end
            ST_EXT, ST_EXT_CR: begin
                use_const = 1'b0;
                addend    = SUM_W'(5);
            end
            ST_DATA: begin
                use_const = 1'b0;
                addend    = SUM_W'(4);
            end
            ST_AFTER, ST_AFTER_CR:           addend = SUM_W'(4);
            ST_LAST_EXT, ST_LAST_EXT_CR:     addend = SUM_W'(2);
            ST_TRAILER, ST_TRAILER_CR:       addend = SUM_W'(1);
            default:                         addend = SUM_W'(2);
        endcase
        sum = use_const ? addend : (SUM_W'(n_chunk) + addend);
        if (sum > SUM_W'({MINREM_W{1'b1}})) begin
            min_rem = {MINREM_W{1'b1}};
        end else begin
            min_rem = sum[MINREM_W-1:0];
        end
    end

    // Pack the result; errors and message end carry no estimate.
    always_comb begin
        o_res.kind          = kind;
        o_res.state         = n_state;
        o_res.payload_byte  = (kind == K_PAYLOAD) ? i_byte : 8'd0;
        o_res.min_remaining = (kind == K_FRAME || kind == K_PAYLOAD) ? min_rem : '0;
        o_chunk             = n_chunk;
    end

endmodule
